// ===== rtl/json_shape_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// JSON shape tracker assertion macros
// Shared property forms for the checker of the tracker.
// ----------------------------------------------------------------------------
`ifndef JSON_SHAPE_TRACKER_DEFINES_SVH
`define JSON_SHAPE_TRACKER_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define JST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json shape tracker check failed");

// Next-cycle implication, muted while reset is asserted.
`define JST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json shape tracker check failed");

`endif

// ===== rtl/jst_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON shape tracker package
// Position state encoding, character codes, masks and result widths.
// ----------------------------------------------------------------------------
`default_nettype none

package jst_pkg;

  localparam int CHAR_W      = 8;
  localparam int CODE_W      = 4;
  localparam int MASK_W      = 8;
  localparam int LEVEL_W     = 8;
  // Result bits other than the stack level.
  localparam int RES_FIXED_W = CODE_W + MASK_W + 2 + 2 * LEVEL_W + 1;

  // Command codes.
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Position state codes as seen on the result beat and in the stack.
  localparam logic [CODE_W-1:0] CODE_OPEN       = 4'd0;
  localparam logic [CODE_W-1:0] CODE_KEYQ       = 4'd1;
  localparam logic [CODE_W-1:0] CODE_KEY        = 4'd2;
  localparam logic [CODE_W-1:0] CODE_COLON      = 4'd3;
  localparam logic [CODE_W-1:0] CODE_VALUE      = 4'd4;
  localparam logic [CODE_W-1:0] CODE_STR        = 4'd5;
  localparam logic [CODE_W-1:0] CODE_NUM        = 4'd6;
  localparam logic [CODE_W-1:0] CODE_BOOL       = 4'd7;
  localparam logic [CODE_W-1:0] CODE_NULL       = 4'd8;
  localparam logic [CODE_W-1:0] CODE_ARRAY      = 4'd9;
  localparam logic [CODE_W-1:0] CODE_COMMACLOSE = 4'd10;
  localparam logic [CODE_W-1:0] CODE_DONE       = 4'd11;

  // Internal one-hot position state.
  typedef enum logic [11:0] {
    PS_OPEN       = 12'h001,
    PS_KEYQ       = 12'h002,
    PS_KEY        = 12'h004,
    PS_COLON      = 12'h008,
    PS_VALUE      = 12'h010,
    PS_STR        = 12'h020,
    PS_NUM        = 12'h040,
    PS_BOOL       = 12'h080,
    PS_NULL       = 12'h100,
    PS_ARRAY      = 12'h200,
    PS_COMMACLOSE = 12'h400,
    PS_DONE       = 12'h800
  } ps_t;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  // Allowed-class masks per state.
  localparam logic [MASK_W-1:0] MASK_OPEN       = 8'h01;
  localparam logic [MASK_W-1:0] MASK_KEYQ       = 8'h0A;
  localparam logic [MASK_W-1:0] MASK_COLON      = 8'h10;
  localparam logic [MASK_W-1:0] MASK_VALUE      = 8'hCD;
  localparam logic [MASK_W-1:0] MASK_COMMACLOSE = 8'h22;
  localparam logic [MASK_W-1:0] MASK_NONE       = 8'h00;

  // Depth saturation limits.
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX  = 8'sh7F;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN  = 8'sh80;
  localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO = 8'sh00;
  localparam logic signed [LEVEL_W-1:0] LEVEL_ONE  = 8'sh01;

  function automatic logic [CODE_W-1:0] ps_encode(input ps_t ps);
    logic [CODE_W-1:0] code;
    unique case (ps)
      PS_OPEN:       code = CODE_OPEN;
      PS_KEYQ:       code = CODE_KEYQ;
      PS_KEY:        code = CODE_KEY;
      PS_COLON:      code = CODE_COLON;
      PS_VALUE:      code = CODE_VALUE;
      PS_STR:        code = CODE_STR;
      PS_NUM:        code = CODE_NUM;
      PS_BOOL:       code = CODE_BOOL;
      PS_NULL:       code = CODE_NULL;
      PS_ARRAY:      code = CODE_ARRAY;
      PS_COMMACLOSE: code = CODE_COMMACLOSE;
      PS_DONE:       code = CODE_DONE;
      default:       code = CODE_OPEN;
    endcase
    return code;
  endfunction

  function automatic ps_t ps_decode(input logic [CODE_W-1:0] code);
    ps_t ps;
    unique case (code)
      CODE_OPEN:       ps = PS_OPEN;
      CODE_KEYQ:       ps = PS_KEYQ;
      CODE_KEY:        ps = PS_KEY;
      CODE_COLON:      ps = PS_COLON;
      CODE_VALUE:      ps = PS_VALUE;
      CODE_STR:        ps = PS_STR;
      CODE_NUM:        ps = PS_NUM;
      CODE_BOOL:       ps = PS_BOOL;
      CODE_NULL:       ps = PS_NULL;
      CODE_ARRAY:      ps = PS_ARRAY;
      CODE_COMMACLOSE: ps = PS_COMMACLOSE;
      CODE_DONE:       ps = PS_DONE;
      default:         ps = PS_OPEN;
    endcase
    return ps;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jst_ifs.sv =====
// ----------------------------------------------------------------------------
// JSON shape tracker channels
// Valid/ready stream interfaces for the character and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface jst_in_if import jst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CHAR_W-1:0] char_code;

  modport source(output valid, opcode, char_code, input ready);
  modport sink(input valid, opcode, char_code, output ready);
endinterface

interface jst_out_if import jst_pkg::*; #(
  parameter int SP_W = 5
) ();
  logic                      valid;
  logic                      ready;
  logic [CODE_W-1:0]         parse_state;
  logic [MASK_W-1:0]         allowed_mask;
  logic                      free_generation;
  logic                      block_all;
  logic signed [LEVEL_W-1:0] brace_level;
  logic signed [LEVEL_W-1:0] bracket_level;
  logic [SP_W-1:0]           stack_level;
  logic                      overflow_flag;

  modport source(
    output valid, parse_state, allowed_mask, free_generation, block_all,
           brace_level, bracket_level, stack_level, overflow_flag,
    input  ready
  );
  modport sink(
    input  valid, parse_state, allowed_mask, free_generation, block_all,
           brace_level, bracket_level, stack_level, overflow_flag,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/jst_ram.sv =====
// ----------------------------------------------------------------------------
// JSON shape tracker RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write, and read the old contents on an address collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/jst_skid.sv =====
// ----------------------------------------------------------------------------
// JSON shape tracker output buffer
// Two-entry output register with skid stage; ready does not depend on
// the downstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_skid #(
  parameter int W = 36
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         main_valid_r;
  logic [W-1:0] main_data_r;
  logic         skid_valid_r;
  logic [W-1:0] skid_data_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  // Advance the main register when it drains; park a beat in the skid otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        main_data_r  <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= in_valid;
        if (in_valid) begin
          main_data_r <= in_data;
        end
      end
    end else if (in_valid && in_ready) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/json_shape_tracker.sv =====
// ----------------------------------------------------------------------------
// JSON shape tracker
// Follows a loose JSON object shape one character at a time and reports the
// token classes allowed next.
// ----------------------------------------------------------------------------
// The tracker takes one character or restart beat per clock while the
// output buffer has room, and returns one registered result beat per input
// beat, in order. The whole state update is combinational; the return stack
// lives in a small RAM whose registered read is kept pointed at the top
// entry, with the value of a push forwarded around the RAM, so a pop right
// after a push costs nothing. A two-entry output buffer lets the input keep
// flowing for one beat while a result waits. No clearing pass follows reset:
// the stack is only read below the pointer, which reset clears.
`default_nettype none

module json_shape_tracker import jst_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  jst_in_if.sink    in_bus,
  jst_out_if.source out_bus
);

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int RES_W = RES_FIXED_W + SP_W;

  ps_t                       ps_r, ps_nxt;
  logic                      esc_r, esc_nxt;
  logic signed [LEVEL_W-1:0] brace_r, brace_nxt;
  logic signed [LEVEL_W-1:0] bracket_r, bracket_nxt;
  logic [SP_W-1:0]           sp_r, sp_nxt;
  logic                      fwd_r, fwd_nxt;
  logic [CODE_W-1:0]         fwd_data_r;

  logic                      in_fire;
  logic [CHAR_W-1:0]         ch;
  logic                      push_en;
  logic [CODE_W-1:0]         push_code;
  logic                      ovf;
  logic                      pop_ok;
  logic [CODE_W-1:0]         ram_rdata;
  logic [CODE_W-1:0]         tos_code;
  ps_t                       tos_ps;
  logic [AW-1:0]             wr_addr;
  logic [SP_W-1:0]           rd_addr_full;
  logic [AW-1:0]             rd_addr;
  logic [MASK_W-1:0]         mask;
  logic                      free_gen;
  logic                      blk;
  logic [RES_W-1:0]          res_data;
  logic [RES_W-1:0]          out_data;

  assign in_fire = in_bus.valid && in_bus.ready;
  assign ch      = in_bus.char_code;

  // Top of stack: last push forwarded, else the registered RAM read.
  assign tos_code = fwd_r ? fwd_data_r : ram_rdata;
  assign tos_ps   = ps_decode(tos_code);
  assign pop_ok   = (sp_r != '0);

  // Next state for an accepted beat.
  always_comb begin
    ps_nxt      = ps_r;
    esc_nxt     = esc_r;
    brace_nxt   = brace_r;
    bracket_nxt = bracket_r;
    sp_nxt      = sp_r;
    push_en     = 1'b0;
    push_code   = CODE_ARRAY;
    ovf         = 1'b0;
    if (in_fire) begin
      if (in_bus.opcode == OP_RESTART) begin
        ps_nxt      = PS_OPEN;
        esc_nxt     = 1'b0;
        brace_nxt   = LEVEL_ZERO;
        bracket_nxt = LEVEL_ZERO;
        sp_nxt      = '0;
      end else begin
        // Depths move first, saturating.
        if (ch == CH_LBRACE) begin
          if (brace_r != LEVEL_MAX) brace_nxt = brace_r + LEVEL_ONE;
        end else if (ch == CH_RBRACE) begin
          if (brace_r != LEVEL_MIN) brace_nxt = brace_r - LEVEL_ONE;
        end else if (ch == CH_LBRACK) begin
          if (bracket_r != LEVEL_MAX) bracket_nxt = bracket_r + LEVEL_ONE;
        end else if (ch == CH_RBRACK) begin
          if (bracket_r != LEVEL_MIN) bracket_nxt = bracket_r - LEVEL_ONE;
        end

        unique case (ps_r) inside
          PS_OPEN: begin
            if (ch == CH_LBRACE) ps_nxt = PS_KEYQ;
          end
          PS_KEYQ: begin
            if (ch == CH_QUOTE) ps_nxt = PS_KEY;
            else if (ch == CH_RBRACE) ps_nxt = PS_DONE;
          end
          PS_KEY: begin
            if (ch == CH_QUOTE && !esc_r) ps_nxt = PS_COLON;
            else if (ch == CH_BSLASH) esc_nxt = !esc_r;
            else esc_nxt = 1'b0;
          end
          PS_COLON: begin
            if (ch == CH_COLON) ps_nxt = PS_VALUE;
          end
          PS_VALUE: begin
            if (ch == CH_QUOTE) begin
              ps_nxt = PS_STR;
            end else if (ch == CH_LBRACK || ch == CH_LBRACE) begin
              push_code = (ch == CH_LBRACK) ? CODE_ARRAY : CODE_COMMACLOSE;
              if (sp_r == SP_W'(STACK_DEPTH)) begin
                ovf = 1'b1;
              end else begin
                push_en = 1'b1;
                sp_nxt  = sp_r + SP_W'(1);
              end
              if (ch == CH_LBRACE) ps_nxt = PS_KEYQ;
            end else if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_MINUS) begin
              ps_nxt = PS_NUM;
            end else if (ch == CH_T || ch == CH_F) begin
              ps_nxt = PS_BOOL;
            end else if (ch == CH_N) begin
              ps_nxt = PS_NULL;
            end
          end
          PS_STR: begin
            if (ch == CH_QUOTE && !esc_r) begin
              if (pop_ok) begin
                sp_nxt = sp_r - SP_W'(1);
                ps_nxt = tos_ps;
              end else begin
                ps_nxt = PS_COMMACLOSE;
              end
            end else if (ch == CH_BSLASH) begin
              esc_nxt = !esc_r;
            end else begin
              esc_nxt = 1'b0;
            end
          end
          PS_NUM, PS_BOOL, PS_NULL: begin
            if (ch == CH_COMMA || ch == CH_RBRACE || ch == CH_RBRACK) begin
              if (pop_ok) begin
                sp_nxt = sp_r - SP_W'(1);
                ps_nxt = tos_ps;
              end else begin
                ps_nxt = PS_COMMACLOSE;
              end
              // Terminator overrides the popped state.
              if (ch == CH_COMMA) ps_nxt = PS_KEYQ;
              else if (ch == CH_RBRACE && brace_nxt == LEVEL_ZERO) ps_nxt = PS_DONE;
              else if (ch == CH_RBRACK) ps_nxt = PS_COMMACLOSE;
            end
          end
          PS_ARRAY: begin
            if (ch == CH_RBRACK) begin
              if (pop_ok) begin
                sp_nxt = sp_r - SP_W'(1);
                ps_nxt = tos_ps;
              end else begin
                ps_nxt = PS_COMMACLOSE;
              end
            end else if (ch == CH_COMMA) begin
              ps_nxt = PS_VALUE;
            end
          end
          PS_COMMACLOSE: begin
            if (ch == CH_COMMA) begin
              ps_nxt = PS_KEYQ;
            end else if (ch == CH_RBRACE) begin
              if (brace_nxt == LEVEL_ZERO) begin
                ps_nxt = PS_DONE;
              end else if (pop_ok) begin
                sp_nxt = sp_r - SP_W'(1);
                ps_nxt = tos_ps;
              end
            end
          end
          PS_DONE: begin
            ps_nxt = PS_DONE;
          end
          default: begin
            ps_nxt = ps_r;
          end
        endcase
      end
    end
  end

  // Keep the RAM read pointed at the entry below the next pointer.
  assign wr_addr      = sp_r[AW-1:0];
  assign rd_addr_full = sp_nxt - SP_W'(1);
  assign rd_addr      = rd_addr_full[AW-1:0];
  assign fwd_nxt      = push_en && (wr_addr == rd_addr);

  jst_ram #(
    .W     (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_en),
    .waddr (wr_addr),
    .wdata (push_code),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Decode the mask and generation flags from the new state.
  always_comb begin
    mask     = MASK_NONE;
    free_gen = 1'b0;
    blk      = 1'b0;
    unique case (ps_nxt)
      PS_OPEN:       mask = MASK_OPEN;
      PS_KEYQ:       mask = MASK_KEYQ;
      PS_COLON:      mask = MASK_COLON;
      PS_VALUE:      mask = MASK_VALUE;
      PS_COMMACLOSE: mask = MASK_COMMACLOSE;
      PS_DONE:       blk  = 1'b1;
      default:       free_gen = 1'b1;
    endcase
  end

  // Hold the tracker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r      <= PS_OPEN;
      esc_r     <= 1'b0;
      brace_r   <= LEVEL_ZERO;
      bracket_r <= LEVEL_ZERO;
      sp_r      <= '0;
      fwd_r     <= 1'b0;
    end else begin
      ps_r      <= ps_nxt;
      esc_r     <= esc_nxt;
      brace_r   <= brace_nxt;
      bracket_r <= bracket_nxt;
      sp_r      <= sp_nxt;
      fwd_r     <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= push_code;
  end

  assign res_data = {ovf, sp_nxt, bracket_nxt, brace_nxt, blk, free_gen, mask,
                     ps_encode(ps_nxt)};

  jst_skid #(
    .W (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_data   (res_data),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_data)
  );

  assign {out_bus.overflow_flag, out_bus.stack_level, out_bus.bracket_level,
          out_bus.brace_level, out_bus.block_all, out_bus.free_generation,
          out_bus.allowed_mask, out_bus.parse_state} = out_data;

endmodule

`default_nettype wire

// ===== rtl/jst_checker.sv =====
// ----------------------------------------------------------------------------
// JSON shape tracker checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_shape_tracker_defines.svh"

module jst_checker import jst_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [CODE_W-1:0]             parse_state,
  input wire logic [MASK_W-1:0]             allowed_mask,
  input wire logic                          free_generation,
  input wire logic                          block_all,
  input wire logic [$clog2(STACK_DEPTH+1)-1:0] stack_level,
  input wire logic                          overflow_flag
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  // Done blocks everything and shows no class.
  `JST_ASSERT_SAME(a_done_blocks, clk, rst_n, out_valid && block_all, (parse_state == CODE_DONE) && (allowed_mask == MASK_NONE) && !free_generation)

  // Free generation carries no class mask.
  `JST_ASSERT_SAME(a_free_no_mask, clk, rst_n, out_valid && free_generation, (allowed_mask == MASK_NONE) && !block_all)

  // A dropped push only happens on a full stack.
  `JST_ASSERT_SAME(a_ovf_full, clk, rst_n, out_valid && overflow_flag, stack_level == SP_W'(STACK_DEPTH))

  // Stack level never exceeds the depth.
  `JST_ASSERT_SAME(a_level_range, clk, rst_n, out_valid, stack_level <= SP_W'(STACK_DEPTH))

  // A stalled beat holds.
  `JST_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(parse_state) && $stable(stack_level))

endmodule

bind json_shape_tracker jst_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_jst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .parse_state     (out_bus.parse_state),
  .allowed_mask    (out_bus.allowed_mask),
  .free_generation (out_bus.free_generation),
  .block_all       (out_bus.block_all),
  .stack_level     (out_bus.stack_level),
  .overflow_flag   (out_bus.overflow_flag)
);

`default_nettype wire

// ===== verif/json_shape_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON shape tracker testbench
// Feeds character and restart beats through the tracker with random gaps on
// both channels and one long result hold-off. Every result beat is compared,
// field by field and in order, with a scripted shape or a cycle-free shadow
// of the tracker. A short scripted opening covers the depth limits, the
// stack drop, escapes and the closed state. Random documents follow, mostly
// well formed with random content, and some carry stray bytes and restarts.
// ----------------------------------------------------------------------------
module json_shape_tracker_tb import jst_pkg::*; ();

  localparam int STACK_DEPTH  = 16;
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);
  localparam int RANDOM_BEATS = 900;
  localparam int SCRIPT_LEN   = 26;

  typedef struct packed {
    logic [CODE_W-1:0]         state;
    logic [MASK_W-1:0]         mask;
    logic                      free_gen;
    logic                      blocked;
    logic signed [LEVEL_W-1:0] brace;
    logic signed [LEVEL_W-1:0] bracket;
    logic [SP_W-1:0]           level;
    logic                      dropped;
  } shape_t;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
  } char_beat_t;

  typedef struct packed {
    char_beat_t beat;
    logic [7:0] reps;
    logic       typed;
    shape_t     shape;
  } script_row_t;

  localparam shape_t RESET_SHAPE =
    '{CODE_OPEN, MASK_OPEN, 1'b0, 1'b0, LEVEL_ZERO, LEVEL_ZERO, '0, 1'b0};
  localparam shape_t CLOSED_SHAPE =
    '{CODE_DONE, MASK_NONE, 1'b0, 1'b1, LEVEL_ZERO, LEVEL_ZERO, '0, 1'b0};

  // Opening script: a typed shape is checked on the last repeat of its row.
  localparam script_row_t SHAPE_SCRIPT [SCRIPT_LEN] = '{
    '{'{OP_RESTART, 8'h00}, 8'd1, 1'b1, RESET_SHAPE},
    '{'{OP_PROCESS, 8'h00}, 8'd1, 1'b1, RESET_SHAPE},
    '{'{OP_PROCESS, CH_RBRACE}, 8'd130, 1'b1,
      '{CODE_OPEN, MASK_OPEN, 1'b0, 1'b0, LEVEL_MIN, LEVEL_ZERO, '0, 1'b0}},
    '{'{OP_PROCESS, CH_RBRACK}, 8'd130, 1'b1,
      '{CODE_OPEN, MASK_OPEN, 1'b0, 1'b0, LEVEL_MIN, LEVEL_MIN, '0, 1'b0}},
    '{'{OP_RESTART, 8'h00}, 8'd1, 1'b1, RESET_SHAPE},
    '{'{OP_PROCESS, CH_LBRACE}, 8'd130, 1'b1,
      '{CODE_KEYQ, MASK_KEYQ, 1'b0, 1'b0, LEVEL_MAX, LEVEL_ZERO, '0, 1'b0}},
    '{'{OP_PROCESS, CH_LBRACK}, 8'd130, 1'b1,
      '{CODE_KEYQ, MASK_KEYQ, 1'b0, 1'b0, LEVEL_MAX, LEVEL_MAX, '0, 1'b0}},
    '{'{OP_RESTART, 8'hFF}, 8'd1, 1'b1, RESET_SHAPE},
    '{'{OP_PROCESS, CH_LBRACE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_QUOTE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_BSLASH}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_QUOTE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_BSLASH}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_BSLASH}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_QUOTE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_COLON}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_LBRACK}, 8'd17, 1'b1,
      '{CODE_VALUE, MASK_VALUE, 1'b0, 1'b0, LEVEL_ONE, 8'sd17, 5'd16, 1'b1}},
    '{'{OP_PROCESS, CH_LBRACE}, 8'd1, 1'b0, '0},
    '{'{OP_RESTART, 8'h00}, 8'd1, 1'b1, RESET_SHAPE},
    '{'{OP_PROCESS, CH_LBRACE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_QUOTE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_QUOTE}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_COLON}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_F}, 8'd1, 1'b0, '0},
    '{'{OP_PROCESS, CH_RBRACE}, 8'd1, 1'b1, CLOSED_SHAPE},
    '{'{OP_PROCESS, 8'hFF}, 8'd1, 1'b1, CLOSED_SHAPE}
  };

  logic clk;
  logic rst_n;

  jst_in_if                 in_bus ();
  jst_out_if #(.SP_W(SP_W)) out_bus ();

  json_shape_tracker #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Shadow tracker state.
  logic [CODE_W-1:0]         trk_state;
  logic                      trk_escape;
  logic signed [LEVEL_W-1:0] trk_brace;
  logic signed [LEVEL_W-1:0] trk_bracket;
  logic [CODE_W-1:0]         trk_stack [STACK_DEPTH];
  int unsigned               trk_depth;

  shape_t     pending_shapes [$];
  char_beat_t text_beats [$];

  int beats_sent     = 0;
  int restarts_sent  = 0;
  int shapes_checked = 0;
  int mismatches     = 0;
  int drops_seen     = 0;
  int closed_seen    = 0;
  int src_idle_pct   = 24;
  int sink_idle_pct  = 24;
  int noise_pct      = 0;

  function automatic void clear_tracker();
    trk_state   = CODE_OPEN;
    trk_escape  = 1'b0;
    trk_brace   = LEVEL_ZERO;
    trk_bracket = LEVEL_ZERO;
    trk_depth   = 0;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] nudge_level(
    input logic signed [LEVEL_W-1:0] lvl,
    input logic                      up
  );
    if (up) return (lvl == LEVEL_MAX) ? lvl : lvl + LEVEL_ONE;
    return (lvl == LEVEL_MIN) ? lvl : lvl - LEVEL_ONE;
  endfunction

  // Save a return state; report 0 when the stack is full.
  function automatic logic push_return(input logic [CODE_W-1:0] code);
    if (trk_depth >= STACK_DEPTH) return 1'b0;
    trk_stack[trk_depth] = code;
    trk_depth++;
    return 1'b1;
  endfunction

  function automatic void pop_return(input logic [CODE_W-1:0] fallback);
    if (trk_depth > 0) begin
      trk_depth--;
      trk_state = trk_stack[trk_depth];
    end else begin
      trk_state = fallback;
    end
  endfunction

  // Quoted text: a backslash toggles the escape, an unescaped quote closes.
  function automatic void scan_quoted(
    input logic [CHAR_W-1:0] c,
    input logic [CODE_W-1:0] next
  );
    if (c == CH_QUOTE && !trk_escape) begin
      if (next == CODE_COMMACLOSE) pop_return(CODE_COMMACLOSE);
      else trk_state = next;
    end else if (c == CH_BSLASH) begin
      trk_escape = !trk_escape;
    end else begin
      trk_escape = 1'b0;
    end
  endfunction

  // Advance the shadow tracker by one beat and return the shape it reports.
  function automatic shape_t track_beat(input logic op, input logic [CHAR_W-1:0] c);
    shape_t s;
    logic   drop;
    drop = 1'b0;
    if (op == OP_RESTART) begin
      clear_tracker();
    end else begin
      // Depths move before the position rule sees the character.
      if (c == CH_LBRACE) trk_brace = nudge_level(trk_brace, 1'b1);
      else if (c == CH_RBRACE) trk_brace = nudge_level(trk_brace, 1'b0);
      else if (c == CH_LBRACK) trk_bracket = nudge_level(trk_bracket, 1'b1);
      else if (c == CH_RBRACK) trk_bracket = nudge_level(trk_bracket, 1'b0);

      case (trk_state) inside
        CODE_OPEN: begin
          if (c == CH_LBRACE) trk_state = CODE_KEYQ;
        end
        CODE_KEYQ: begin
          if (c == CH_QUOTE) trk_state = CODE_KEY;
          else if (c == CH_RBRACE) trk_state = CODE_DONE;
        end
        CODE_KEY: scan_quoted(c, CODE_COLON);
        CODE_COLON: begin
          if (c == CH_COLON) trk_state = CODE_VALUE;
        end
        CODE_VALUE: begin
          if (c == CH_QUOTE) begin
            trk_state = CODE_STR;
          end else if (c == CH_LBRACK) begin
            drop = !push_return(CODE_ARRAY);
          end else if (c == CH_LBRACE) begin
            drop = !push_return(CODE_COMMACLOSE);
            trk_state = CODE_KEYQ;
          end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS) begin
            trk_state = CODE_NUM;
          end else if (c == CH_T || c == CH_F) begin
            trk_state = CODE_BOOL;
          end else if (c == CH_N) begin
            trk_state = CODE_NULL;
          end
        end
        CODE_STR: scan_quoted(c, CODE_COMMACLOSE);
        CODE_NUM, CODE_BOOL, CODE_NULL: begin
          if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
            pop_return(CODE_COMMACLOSE);
            if (c == CH_COMMA) trk_state = CODE_KEYQ;
            else if (c == CH_RBRACE && trk_brace == LEVEL_ZERO) trk_state = CODE_DONE;
            else if (c == CH_RBRACK) trk_state = CODE_COMMACLOSE;
          end
        end
        CODE_ARRAY: begin
          if (c == CH_RBRACK) pop_return(CODE_COMMACLOSE);
          else if (c == CH_COMMA) trk_state = CODE_VALUE;
        end
        CODE_COMMACLOSE: begin
          if (c == CH_COMMA) begin
            trk_state = CODE_KEYQ;
          end else if (c == CH_RBRACE) begin
            if (trk_brace == LEVEL_ZERO) trk_state = CODE_DONE;
            else if (trk_depth > 0) pop_return(CODE_COMMACLOSE);
          end
        end
        default: ;
      endcase
    end

    // Derive the allowed classes from the new position.
    s.state    = trk_state;
    s.mask     = MASK_NONE;
    s.free_gen = 1'b0;
    s.blocked  = 1'b0;
    case (trk_state)
      CODE_OPEN:       s.mask = MASK_OPEN;
      CODE_KEYQ:       s.mask = MASK_KEYQ;
      CODE_COLON:      s.mask = MASK_COLON;
      CODE_VALUE:      s.mask = MASK_VALUE;
      CODE_COMMACLOSE: s.mask = MASK_COMMACLOSE;
      CODE_DONE:       s.blocked = 1'b1;
      default:         s.free_gen = 1'b1;
    endcase
    s.brace   = trk_brace;
    s.bracket = trk_bracket;
    s.level   = SP_W'(trk_depth);
    s.dropped = drop;
    return s;
  endfunction

  // Queue one beat at the end of the generated text.
  function automatic void append_beat(input logic op, input logic [CHAR_W-1:0] c);
    char_beat_t b;
    b.op = op;
    b.ch = c;
    text_beats.insert(text_beats.size(), b);
  endfunction

  // Append one character of generated text, corrupted now and then.
  function automatic void put_char(input logic [CHAR_W-1:0] c);
    if (noise_pct > 0 && $urandom_range(99) < noise_pct) begin
      if ($urandom_range(15) == 0) append_beat(OP_RESTART, CHAR_W'($urandom));
      else append_beat(OP_PROCESS, CHAR_W'($urandom));
    end else begin
      append_beat(OP_PROCESS, c);
    end
  endfunction

  // Quoted text with letters and the odd escape sequence.
  function automatic void put_quoted();
    put_char(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(5) == 0) begin
        put_char(CH_BSLASH);
        case ($urandom_range(2))
          0:       put_char(CH_QUOTE);
          1:       put_char(CH_BSLASH);
          default: put_char(CH_N);
        endcase
      end else begin
        put_char(CHAR_W'($urandom_range(8'h7A, 8'h61)));
      end
    end
    put_char(CH_QUOTE);
  endfunction

  function automatic void put_scalar();
    string word;
    case ($urandom_range(3))
      0: put_quoted();
      1: begin
        if ($urandom_range(1) == 1) put_char(CH_MINUS);
        repeat ($urandom_range(4, 1)) put_char(CH_ZERO + CHAR_W'($urandom_range(9)));
      end
      default: begin
        case ($urandom_range(2))
          0:       word = "true";
          1:       word = "false";
          default: word = "null";
        endcase
        for (int i = 0; i < word.len(); i++) put_char(word[i]);
      end
    endcase
  endfunction

  // Emit one object; a chain nests one member per level down to max_nest.
  function automatic void put_document(input int max_nest, input int nest_pct, input bit chain);
    bit open_obj [$];
    int members_left [$];
    bit started [$];
    int top;
    bit obj;
    put_char(CH_LBRACE);
    open_obj.insert(open_obj.size(), 1'b1);
    members_left.insert(members_left.size(), chain ? 1 : int'($urandom_range(3)));
    started.insert(started.size(), 1'b0);
    while (open_obj.size() != 0) begin
      top = open_obj.size() - 1;
      if (members_left[top] == 0) begin
        put_char(open_obj[top] ? CH_RBRACE : CH_RBRACK);
        void'(open_obj.pop_back());
        void'(members_left.pop_back());
        void'(started.pop_back());
      end else begin
        if (started[top]) put_char(CH_COMMA);
        started[top] = 1'b1;
        members_left[top] = members_left[top] - 1;
        if (open_obj[top]) begin
          put_quoted();
          put_char(CH_COLON);
        end
        if (open_obj.size() < max_nest && $urandom_range(99) < nest_pct) begin
          obj = 1'($urandom_range(1));
          put_char(obj ? CH_LBRACE : CH_LBRACK);
          open_obj.insert(open_obj.size(), obj);
          members_left.insert(members_left.size(), chain ? 1 : int'($urandom_range(3)));
          started.insert(started.size(), 1'b0);
        end else begin
          put_scalar();
        end
      end
    end
  endfunction

  // Offer one beat after a random gap, wait for the handshake, then predict.
  task automatic send_beat(input char_beat_t b, input logic typed, input shape_t typed_shape);
    shape_t want;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= b.op;
    in_bus.char_code <= b.ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    want = track_beat(b.op, b.ch);
    pending_shapes.insert(pending_shapes.size(), typed ? typed_shape : want);
    beats_sent++;
    if (b.op == OP_RESTART) restarts_sent++;
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop.
  initial begin : watchdog
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back up the input.
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && shapes_checked >= 700) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= !(sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    shape_t got;
    shape_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.parse_state, out_bus.allowed_mask, out_bus.free_generation,
              out_bus.block_all, out_bus.brace_level, out_bus.bracket_level,
              out_bus.stack_level, out_bus.overflow_flag};
      shapes_checked++;
      if (got.dropped) drops_seen++;
      if (got.state == CODE_DONE) closed_seen++;
      if (pending_shapes.size() == 0) begin
        $error("result beat with no prediction waiting (parse_state %0d)", got.state);
        mismatches++;
      end else begin
        want = pending_shapes.pop_front();
        check_field("parse_state", int'(want.state), int'(got.state));
        check_field("allowed_mask", int'(want.mask), int'(got.mask));
        check_field("free_generation", int'(want.free_gen), int'(got.free_gen));
        check_field("block_all", int'(want.blocked), int'(got.blocked));
        check_field("brace_level", int'($signed(want.brace)), int'($signed(got.brace)));
        check_field("bracket_level", int'($signed(want.bracket)), int'($signed(got.bracket)));
        check_field("stack_level", int'(want.level), int'(got.level));
        check_field("overflow_flag", int'(want.dropped), int'(got.dropped));
      end
    end
  end

  // Stimulus: reset, opening script, then random documents.
  initial begin : stimulus
    int random_fed;
    int pick;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = OP_PROCESS;
    in_bus.char_code = '0;
    random_fed       = 0;
    clear_tracker();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the script; repeated rows drive the depths and the stack to their limits.
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      for (int k = 1; k <= SHAPE_SCRIPT[r].reps; k++) begin
        send_beat(SHAPE_SCRIPT[r].beat, SHAPE_SCRIPT[r].typed && k == SHAPE_SCRIPT[r].reps,
                  SHAPE_SCRIPT[r].shape);
      end
    end

    // Each document starts from a restart; some are deep chains, some carry noise.
    while (random_fed < RANDOM_BEATS) begin
      text_beats.delete();
      noise_pct = 0;
      append_beat(OP_RESTART, CHAR_W'($urandom));
      noise_pct = ($urandom_range(3) == 0) ? 6 : 0;
      pick = $urandom_range(99);
      if (pick < 12) put_document(20, 100, 1'b1);
      else put_document(4, 30, 1'b0);
      foreach (text_beats[i]) begin
        // Hold both sides busy through one stretch of the run.
        src_idle_pct  = (random_fed >= 300 && random_fed < 600) ? 0 : 24;
        sink_idle_pct = src_idle_pct;
        send_beat(text_beats[i], 1'b0, '0);
        random_fed++;
      end
    end
    in_bus.valid <= 1'b0;

    // Drain, then wait for any stray result.
    while (pending_shapes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("run: %0d beats offered (%0d restarts), %0d results compared",
             beats_sent, restarts_sent, shapes_checked);
    $display("run: %0d results with a dropped push, %0d in the closed state",
             drops_seen, closed_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
